// ===== rtl/core/fsg_pkg.sv =====
// Shared types and constants for the falling sand grid block.
// Used by the LFSR and top level; depends on nothing else.
package fsg_pkg;

  localparam int GRID_ROWS  = 128;
  localparam int GRID_COLS  = 256;
  localparam int MAX_RADIUS = 20;

  localparam int ROW_W  = $clog2(GRID_ROWS);
  localparam int COL_W  = $clog2(GRID_COLS);
  localparam int RAD_W  = $clog2(MAX_RADIUS + 1);
  localparam int SQ_W   = 2 * RAD_W + 1;
  localparam int SC_W   = 12;
  localparam int LFSR_W = 16;

  localparam logic [LFSR_W-1:0] SEED_RESET = 16'd44257;
  localparam logic [LFSR_W-1:0] LFSR_TAPS  = 16'hB400;

  typedef enum logic [1:0] {
    FUNC_TICK  = 2'd0,
    FUNC_PAINT = 2'd1,
    FUNC_CLEAR = 2'd2,
    FUNC_READ  = 2'd3
  } fsg_func_e;

  typedef struct packed {
    fsg_func_e  func;
    logic [6:0] center_row;
    logic [7:0] center_col;
    logic [4:0] radius;
  } fsg_req_t;

  typedef struct packed {
    logic cell_value;
    logic op_done;
  } fsg_rsp_t;

endpackage

// ===== rtl/core/fsg_row_ram.sv =====
// Single-port synchronous row RAM with registered read.
// Generic storage; no package dependency.
module fsg_row_ram #(
  parameter int DEPTH = 128,
  parameter int WIDTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end

endmodule

// ===== rtl/core/fsg_lfsr.sv =====
// Galois LFSR that picks the diagonal tried first by a blocked grain.
// Depends on fsg_pkg for width, taps and reset seed.
module fsg_lfsr (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       load_i,
  input  logic [fsg_pkg::LFSR_W-1:0] seed_i,
  input  logic                       step_i,
  output logic                       bit_o
);
  import fsg_pkg::*;

  logic [LFSR_W-1:0] lfsr_q, lfsr_d;

  always_comb begin
    lfsr_d = lfsr_q;
    if (load_i) begin
      lfsr_d = seed_i;
    end else if (step_i) begin
      lfsr_d = (lfsr_q >> 1) ^ (lfsr_q[0] ? LFSR_TAPS : '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lfsr_q <= SEED_RESET;
    end else begin
      lfsr_q <= lfsr_d;
    end
  end

  assign bit_o = lfsr_q[0];

endmodule

// ===== rtl/core/falling_sand_grid_step.sv =====
// Falling sand grid: top level with the command sequencer.
// Depends on fsg_pkg, fsg_row_ram and fsg_lfsr.
//
// Usage: drive req_i and raise start_i; the request is taken at a clock
// edge with start_i high and busy_o low. When the operation ends, done_o
// is high for one cycle with rsp_o (cell_value for reads, op_done = 1).
// The receiver cannot stall; every request gives exactly one response.
// The grid sits in a row-wide RAM (one row per entry, one access a cycle).
// Requests share that single RAM port; paint and tick go a column a cycle:
//   read  : the centre row is read and the centre cell returned
//   clear : every row is written to zero
//   paint : each disc row inside the grid is read, painted and written
//           back; the radius is clamped to MAX_RADIUS
//   tick  : the bottom row is scanned first, then each row above is
//           loaded, scanned and written back with the row below it.
// After reset every row of the RAM is swept to zero with busy_o high.
// cfg_we_i loads the seed into the LFSR at once; write it only when idle.
module falling_sand_grid_step (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  fsg_pkg::fsg_req_t req_i,
  output logic              done_o,
  output fsg_pkg::fsg_rsp_t rsp_o,
  input  logic              cfg_we_i,
  input  logic [15:0]       cfg_wdata_i
);
  import fsg_pkg::*;

  typedef enum logic [4:0] {
    ST_INIT, ST_IDLE, ST_CLR, ST_READ, ST_READ_OUT,
    ST_T_BOT_RD, ST_T_BOT_LD, ST_T_BOT_SCAN,
    ST_T_RD, ST_T_LD, ST_T_SCAN, ST_T_WB_LO, ST_T_WB_HI,
    ST_P_ROW, ST_P_LD, ST_P_COL, ST_P_WB
  } state_e;

  state_e   state_q;
  fsg_req_t req_q;
  logic     done_q;
  fsg_rsp_t rsp_q;

  logic [ROW_W-1:0]     row_q;
  logic [COL_W-1:0]     col_q;
  logic [GRID_COLS-1:0] cur_q, below_q;

  logic [RAD_W-1:0]        rad_q;
  logic signed [RAD_W:0]   dr_q, dc_q;
  logic [SQ_W-1:0]         rsq_q, dr2_q;

  logic                 mem_we;
  logic [ROW_W-1:0]     mem_addr;
  logic [GRID_COLS-1:0] mem_wdata, mem_rdata;

  logic lfsr_bit, lfsr_step;

  fsg_row_ram #(.DEPTH(GRID_ROWS), .WIDTH(GRID_COLS)) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  fsg_lfsr u_lfsr (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (cfg_we_i),
    .seed_i (cfg_wdata_i),
    .step_i (lfsr_step),
    .bit_o  (lfsr_bit)
  );

  // request decode
  logic [RAD_W-1:0] rad_c;
  always_comb begin
    rad_c = (32'(req_i.radius) > 32'(MAX_RADIUS)) ? RAD_W'(MAX_RADIUS)
                                                  : RAD_W'(req_i.radius);
  end

  // paint coordinates
  logic signed [SC_W-1:0]   prow, pcol;
  logic signed [2*RAD_W+1:0] dc_sq;
  logic                     prow_in, pcol_in, in_disc;
  always_comb begin
    prow    = SC_W'(signed'({1'b0, req_q.center_row})) + SC_W'(dr_q);
    pcol    = SC_W'(signed'({1'b0, req_q.center_col})) + SC_W'(dc_q);
    prow_in = (prow >= 0) && (prow < SC_W'(GRID_ROWS));
    pcol_in = (pcol >= 0) && (pcol < SC_W'(GRID_COLS));
    dc_sq   = dc_q * dc_q;
    in_disc = ({1'b0, dr2_q} + {1'b0, SQ_W'(dc_sq)}) <= {1'b0, rsq_q};
  end

  // tick cell update
  logic                 grain, lf, rf, go_left, go_right, fall;
  logic [COL_W-1:0]     col_l, col_r;
  logic [GRID_COLS-1:0] cur_n, below_n;
  logic                 col_last;
  always_comb begin
    col_last = (col_q == COL_W'(GRID_COLS - 1));
    col_l    = col_q - 1'b1;
    col_r    = col_q + 1'b1;
    grain    = cur_q[col_q];
    fall     = grain && !below_q[col_q];
    lf       = (col_q != '0) && !below_q[col_l];
    rf       = !col_last && !below_q[col_r];
    go_right = grain && !fall && (lfsr_bit ? rf : (!lf && rf));
    go_left  = grain && !fall && !go_right && lf;
    cur_n    = cur_q;
    below_n  = below_q;
    if (fall) begin
      below_n[col_q] = 1'b1;
    end
    if (go_right) begin
      below_n[col_r] = 1'b1;
    end
    if (go_left) begin
      below_n[col_l] = 1'b1;
    end
    if (fall || go_left || go_right) begin
      cur_n[col_q] = 1'b0;
    end
  end

  always_comb begin
    lfsr_step = 1'b0;
    if (state_q == ST_T_BOT_SCAN) begin
      lfsr_step = cur_q[col_q];
    end else if (state_q == ST_T_SCAN) begin
      lfsr_step = grain && !fall;
    end
  end

  // RAM port
  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = row_q;
    mem_wdata = cur_q;
    unique case (state_q)
      ST_INIT, ST_CLR: begin
        mem_we    = 1'b1;
        mem_wdata = '0;
      end
      ST_READ:     mem_addr = ROW_W'(req_q.center_row);
      ST_T_BOT_RD: mem_addr = ROW_W'(GRID_ROWS - 1);
      ST_T_WB_LO: begin
        mem_we    = 1'b1;
        mem_addr  = row_q + 1'b1;
        mem_wdata = below_q;
      end
      ST_T_WB_HI:        mem_we = 1'b1;
      ST_P_ROW, ST_P_LD, ST_P_COL: mem_addr = prow[ROW_W-1:0];
      ST_P_WB: begin
        mem_we   = 1'b1;
        mem_addr = prow[ROW_W-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
      row_q   <= '0;
      col_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        ST_INIT: begin
          row_q <= row_q + 1'b1;
          if (row_q == ROW_W'(GRID_ROWS - 1)) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (start_i) begin
            req_q <= req_i;
            rad_q <= rad_c;
            rsq_q <= SQ_W'(rad_c) * SQ_W'(rad_c);
            dr_q  <= -signed'({1'b0, rad_c});
            row_q <= '0;
            unique case (req_i.func)
              FUNC_TICK:  state_q <= ST_T_BOT_RD;
              FUNC_PAINT: state_q <= ST_P_ROW;
              FUNC_CLEAR: state_q <= ST_CLR;
              FUNC_READ:  state_q <= ST_READ;
              default:    state_q <= ST_IDLE;
            endcase
          end
        end
        ST_CLR: begin
          row_q <= row_q + 1'b1;
          if (row_q == ROW_W'(GRID_ROWS - 1)) begin
            rsp_q   <= '{cell_value: 1'b0, op_done: 1'b1};
            done_q  <= 1'b1;
            state_q <= ST_IDLE;
          end
        end
        ST_READ: state_q <= ST_READ_OUT;
        ST_READ_OUT: begin
          rsp_q.cell_value <= (32'(req_q.center_row) < 32'(GRID_ROWS)) &&
                              (32'(req_q.center_col) < 32'(GRID_COLS)) &&
                              mem_rdata[COL_W'(req_q.center_col)];
          rsp_q.op_done    <= 1'b1;
          done_q           <= 1'b1;
          state_q          <= ST_IDLE;
        end
        // bottom row: grains stay, but each one steps the LFSR
        ST_T_BOT_RD: state_q <= ST_T_BOT_LD;
        ST_T_BOT_LD: begin
          cur_q   <= mem_rdata;
          col_q   <= '0;
          state_q <= ST_T_BOT_SCAN;
        end
        ST_T_BOT_SCAN: begin
          col_q <= col_r;
          if (col_last) begin
            below_q <= cur_q;
            row_q   <= ROW_W'(GRID_ROWS - 2);
            state_q <= ST_T_RD;
          end
        end
        ST_T_RD: state_q <= ST_T_LD;
        ST_T_LD: begin
          cur_q   <= mem_rdata;
          col_q   <= '0;
          state_q <= ST_T_SCAN;
        end
        ST_T_SCAN: begin
          cur_q   <= cur_n;
          below_q <= below_n;
          col_q   <= col_r;
          if (col_last) begin
            state_q <= ST_T_WB_LO;
          end
        end
        ST_T_WB_LO: state_q <= ST_T_WB_HI;
        ST_T_WB_HI: begin
          if (row_q == '0) begin
            rsp_q   <= '{cell_value: 1'b0, op_done: 1'b1};
            done_q  <= 1'b1;
            state_q <= ST_IDLE;
          end else begin
            below_q <= cur_q;
            row_q   <= row_q - 1'b1;
            state_q <= ST_T_RD;
          end
        end
        // paint: one disc row per RAM read-modify-write
        ST_P_ROW: begin
          if (prow_in) begin
            state_q <= ST_P_LD;
          end else if (dr_q == signed'({1'b0, rad_q})) begin
            rsp_q   <= '{cell_value: 1'b0, op_done: 1'b1};
            done_q  <= 1'b1;
            state_q <= ST_IDLE;
          end else begin
            dr_q <= dr_q + 1'b1;
          end
        end
        ST_P_LD: begin
          cur_q   <= mem_rdata;
          dr2_q   <= SQ_W'(SC_W'(dr_q) * SC_W'(dr_q));
          dc_q    <= -signed'({1'b0, rad_q});
          state_q <= ST_P_COL;
        end
        ST_P_COL: begin
          if (pcol_in && in_disc) begin
            cur_q[pcol[COL_W-1:0]] <= 1'b1;
          end
          if (dc_q == signed'({1'b0, rad_q})) begin
            state_q <= ST_P_WB;
          end else begin
            dc_q <= dc_q + 1'b1;
          end
        end
        ST_P_WB: begin
          if (dr_q == signed'({1'b0, rad_q})) begin
            rsp_q   <= '{cell_value: 1'b0, op_done: 1'b1};
            done_q  <= 1'b1;
            state_q <= ST_IDLE;
          end else begin
            dr_q    <= dr_q + 1'b1;
            state_q <= ST_P_ROW;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign busy_o = (state_q != ST_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

// ===== tb/tb.sv =====
// Testbench for falling_sand_grid_step: directed cases, then random requests.
// Depends on fsg_pkg and the RTL top level; checks every response in order.
`timescale 1ns / 100ps

module tb;
  import fsg_pkg::*;

  localparam int WATCHDOG_LIMIT = 200000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic        busy_o;
  fsg_req_t    req_i = '0;
  logic        done_o;
  fsg_rsp_t    rsp_o;
  logic        cfg_we_i = 1'b0;
  logic [15:0] cfg_wdata_i = '0;

  falling_sand_grid_step DUT (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start_i), .busy_o(busy_o),
    .req_i(req_i), .done_o(done_o), .rsp_o(rsp_o),
    .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // shadow of the block state
  bit          sand_mdl [GRID_ROWS][GRID_COLS];
  logic [15:0] lfsr_mdl;
  fsg_rsp_t    rsp_q [$];
  int          errors = 0;
  int          idle_cycles = 0;
  int          n_ticks = 0, n_paints = 0, n_reads = 0, n_clears = 0, n_hits = 0;

  function automatic bit lfsr_step();
    bit b;
    b = lfsr_mdl[0];
    lfsr_mdl = lfsr_mdl >> 1;
    if (b) lfsr_mdl = lfsr_mdl ^ LFSR_TAPS;
    return b;
  endfunction

  function automatic bit cell_open(int r, int c);
    if (r < 0 || r >= GRID_ROWS || c < 0 || c >= GRID_COLS) return 1'b0;
    return !sand_mdl[r][c];
  endfunction

  function automatic void grid_tick();
    int first, second;
    bit right;
    for (int r = GRID_ROWS - 1; r >= 0; r--) begin
      for (int c = 0; c < GRID_COLS; c++) begin
        if (!sand_mdl[r][c]) continue;
        if (cell_open(r + 1, c)) begin
          sand_mdl[r+1][c] = 1'b1;
          sand_mdl[r][c] = 1'b0;
        end else begin
          right = lfsr_step();
          first = right ? c + 1 : c - 1;
          second = right ? c - 1 : c + 1;
          if (cell_open(r + 1, first)) begin
            sand_mdl[r+1][first] = 1'b1;
            sand_mdl[r][c] = 1'b0;
          end else if (cell_open(r + 1, second)) begin
            sand_mdl[r+1][second] = 1'b1;
            sand_mdl[r][c] = 1'b0;
          end
        end
      end
    end
  endfunction

  function automatic void grid_paint(int cr, int cc, int rad);
    int r, c;
    if (rad > MAX_RADIUS) rad = MAX_RADIUS;
    for (int dr = -rad; dr <= rad; dr++) begin
      for (int dc = -rad; dc <= rad; dc++) begin
        r = cr + dr;
        c = cc + dc;
        if (dr * dr + dc * dc <= rad * rad &&
            r >= 0 && r < GRID_ROWS && c >= 0 && c < GRID_COLS)
          sand_mdl[r][c] = 1'b1;
      end
    end
  endfunction

  function automatic fsg_rsp_t grid_apply(fsg_req_t rq);
    fsg_rsp_t rs;
    rs.cell_value = 1'b0;
    rs.op_done = 1'b1;
    case (rq.func)
      FUNC_TICK: begin
        grid_tick();
        n_ticks++;
      end
      FUNC_PAINT: begin
        grid_paint(int'(rq.center_row), int'(rq.center_col), int'(rq.radius));
        n_paints++;
      end
      FUNC_CLEAR: begin
        foreach (sand_mdl[r, c]) sand_mdl[r][c] = 1'b0;
        n_clears++;
      end
      default: begin
        rs.cell_value = sand_mdl[rq.center_row][rq.center_col];
        n_reads++;
        if (rs.cell_value) n_hits++;
      end
    endcase
    return rs;
  endfunction

  // response checker; done_o cannot be held off
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (rsp_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected response %p", rsp_o);
      end else begin
        fsg_rsp_t want;
        want = rsp_q.pop_front();
        if (rsp_o.cell_value !== want.cell_value || rsp_o.op_done !== want.op_done) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: expected cell_value=%0b op_done=%0b, got %0b %0b",
                     want.cell_value, want.op_done, rsp_o.cell_value, rsp_o.op_done);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start_i && !busy_o) || done_o) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog expired, %0d responses pending", rsp_q.size());
        $display("falling_sand_grid_step verification failed");
        $finish;
      end
    end
  end

  // issue one request; start_i is left high, caller lowers it for a gap
  task automatic send_req(fsg_req_t rq, bit typed, bit typed_val);
    fsg_rsp_t rs;
    start_i <= 1'b1;
    req_i <= rq;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    rs = grid_apply(rq);
    if (typed) begin
      rs.cell_value = typed_val;
    end
    rsp_q.push_back(rs);
  endtask

  task automatic pause(int cycles);
    start_i <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  task automatic drain_and_seed(logic [15:0] seed);
    start_i <= 1'b0;
    @(posedge clk_i);
    while (rsp_q.size() != 0 || busy_o) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= seed;
    lfsr_mdl = seed;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic fsg_req_t mk(fsg_func_e f, int r, int c, int rad);
    fsg_req_t rq;
    rq.func = f;
    rq.center_row = r[6:0];
    rq.center_col = c[7:0];
    rq.radius = rad[4:0];
    return rq;
  endfunction

  typedef struct {
    fsg_req_t rq;
    bit       typed;
    bit       val;
  } dir_row_t;

  initial begin
    dir_row_t dir_tab [19];
    fsg_req_t rq;
    int pr, pc, roll, burst;

    foreach (sand_mdl[r, c]) sand_mdl[r][c] = 1'b0;
    lfsr_mdl = SEED_RESET;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    dir_tab = '{
      '{mk(FUNC_READ, 0, 0, 0), 1, 0},
      '{mk(FUNC_READ, 127, 255, 31), 1, 0},
      '{mk(FUNC_PAINT, 0, 0, 0), 1, 0},           // zero radius: centre only
      '{mk(FUNC_READ, 0, 0, 0), 1, 1},
      '{mk(FUNC_READ, 0, 1, 0), 1, 0},
      '{mk(FUNC_PAINT, 127, 255, 31), 1, 0},      // clamped radius at corner
      '{mk(FUNC_READ, 127, 255, 0), 1, 1},
      '{mk(FUNC_READ, 107, 255, 0), 1, 1},
      '{mk(FUNC_READ, 106, 255, 0), 1, 0},
      '{mk(FUNC_READ, 127, 235, 0), 1, 1},
      '{mk(FUNC_PAINT, 3, 128, 2), 0, 0},         // disc near the top edge, still inside the grid
      '{mk(FUNC_READ, 1, 128, 0), 0, 0},
      '{mk(FUNC_READ, 5, 130, 0), 0, 0},
      '{mk(FUNC_TICK, 0, 0, 0), 1, 0},
      '{mk(FUNC_READ, 4, 128, 0), 0, 0},
      '{mk(FUNC_READ, 106, 255, 0), 0, 0},
      '{mk(FUNC_CLEAR, 0, 0, 0), 1, 0},
      '{mk(FUNC_READ, 127, 255, 0), 1, 0},
      '{mk(FUNC_READ, 1, 128, 0), 1, 0}
    };
    foreach (dir_tab[i]) send_req(dir_tab[i].rq, dir_tab[i].typed, dir_tab[i].val);

    // zero seed: left diagonal always first
    drain_and_seed(16'h0000);
    send_req(mk(FUNC_PAINT, 120, 60, 5), 0, 0);
    send_req(mk(FUNC_TICK, 0, 0, 0), 0, 0);
    send_req(mk(FUNC_READ, 127, 56, 0), 0, 0);
    send_req(mk(FUNC_READ, 126, 64, 0), 0, 0);

    for (int ph = 0; ph < 4; ph++) begin
      drain_and_seed(ph == 0 ? 16'hFFFF : ph == 1 ? 16'h0001 : 16'($urandom_range(1, 65535)));
      pr = $urandom_range(0, 127);
      pc = $urandom_range(0, 255);
      for (int k = 0; k < 25; k++) begin
        roll = $urandom_range(0, 99);
        if (roll < 35) begin
          pr = $urandom_range(0, 127);
          pc = $urandom_range(0, 255);
          rq = mk(FUNC_PAINT, pr, pc, ($urandom_range(0, 9) == 0) ?
                  $urandom_range(0, 31) : $urandom_range(0, 6));
        end else if (roll < 42 && n_ticks < 16) begin
          rq = mk(FUNC_TICK, $urandom, $urandom, $urandom);
        end else if (roll < 45) begin
          rq = mk(FUNC_CLEAR, $urandom, $urandom, $urandom);
        end else if (roll < 52) begin
          rq = mk(FUNC_READ, $urandom, $urandom, $urandom);
        end else begin
          rq = mk(FUNC_READ, pr + $urandom_range(0, 16) - 8,
                  pc + $urandom_range(0, 16) - 8, $urandom);
        end
        send_req(rq, 0, 0);
        burst = $urandom_range(0, 3);
        if (burst == 0) pause($urandom_range(1, 12));
      end
    end

    start_i <= 1'b0;
    @(posedge clk_i);
    while (rsp_q.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    $display("covered %0d ticks, %0d paints, %0d clears, %0d reads (%0d with sand)",
             n_ticks, n_paints, n_clears, n_reads, n_hits);
    $display("seeds: reset, zero, all ones, one, random; mismatches %0d", errors);
    if (errors == 0) begin
      $display("falling_sand_grid_step verification clean");
    end else begin
      $display("falling_sand_grid_step verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/fsg_pkg.sv
rtl/core/fsg_row_ram.sv
rtl/core/fsg_lfsr.sv
rtl/core/falling_sand_grid_step.sv
tb/tb.sv
